### rtl/tspkt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tspkt_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = 8;
    localparam int PID_W        = 13;

    localparam logic [7:0]  SYNC_BYTE = 8'h47;
    localparam logic [7:0]  PAD_BYTE  = 8'hFF;
    localparam logic [7:0]  PTR_BYTE  = 8'h00;
    localparam logic [3:0]  CTRL_NIB  = 4'h1;
    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    localparam logic [3:0] SRC_H0   = 4'd0;
    localparam logic [3:0] SRC_H1   = 4'd1;
    localparam logic [3:0] SRC_H2   = 4'd2;
    localparam logic [3:0] SRC_H3   = 4'd3;
    localparam logic [3:0] SRC_PTR  = 4'd4;
    localparam logic [3:0] SRC_DATA = 4'd5;
    localparam logic [3:0] SRC_CRC0 = 4'd6;
    localparam logic [3:0] SRC_CRC1 = 4'd7;
    localparam logic [3:0] SRC_CRC2 = 4'd8;
    localparam logic [3:0] SRC_CRC3 = 4'd9;
    localparam logic [3:0] SRC_PAD  = 4'd10;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [3:0] src;
        logic       run_last;
        logic       end_section;
    } tspkt_cmd_t;

    typedef struct packed {
        logic pos_zero;
        logic pos_wrap;
        logic word_full;
        logic out_free;
        logic started;
        logic last;
    } tspkt_sts_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {data, 24'h0};
        for (int k = 0; k < 8; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/tspkt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tspkt_ctrl
    import tspkt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire tspkt_sts_t sts,
    output tspkt_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_H0   = 3'd1;
    localparam logic [2:0] ST_H1   = 3'd2;
    localparam logic [2:0] ST_H2   = 3'd3;
    localparam logic [2:0] ST_H3   = 3'd4;
    localparam logic [2:0] ST_PTR  = 3'd5;
    localparam logic [2:0] ST_BODY = 3'd6;
    localparam logic [2:0] ST_PAD  = 3'd7;

    localparam logic [2:0] SEL_DATA = 3'd0;
    localparam logic [2:0] SEL_C0   = 3'd1;
    localparam logic [2:0] SEL_C1   = 3'd2;
    localparam logic [2:0] SEL_C2   = 3'd3;
    localparam logic [2:0] SEL_C3   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] sel_reg, sel_next;
    logic       step_ok;
    logic       tail_final;

    assign step_ok    = !sts.word_full || sts.out_free;
    assign s_tready   = (state_reg == ST_IDLE);
    assign tail_final = (((state_reg == ST_BODY) && (sel_reg == SEL_C3)) ||
                         (state_reg == ST_PAD)) && sts.pos_wrap;

    always_comb begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        cmd.load        = 1'b0;
        cmd.step        = 1'b0;
        cmd.src         = SRC_DATA;
        cmd.end_section = 1'b0;
        if (sts.last) begin
            cmd.run_last = tail_final;
        end else if (state_reg == ST_H1) begin
            cmd.run_last = sts.started;
        end else begin
            cmd.run_last = (state_reg != ST_H0);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    sel_next   = SEL_DATA;
                    state_next = sts.pos_zero ? ST_H0 : ST_BODY;
                end
            end
            ST_H0: begin
                cmd.src  = SRC_H0;
                cmd.step = step_ok;
                if (step_ok) begin
                    state_next = ST_H1;
                end
            end
            ST_H1: begin
                cmd.src  = SRC_H1;
                cmd.step = step_ok;
                if (step_ok) begin
                    state_next = ST_H2;
                end
            end
            ST_H2: begin
                cmd.src  = SRC_H2;
                cmd.step = step_ok;
                if (step_ok) begin
                    state_next = ST_H3;
                end
            end
            ST_H3: begin
                cmd.src  = SRC_H3;
                cmd.step = step_ok;
                if (step_ok) begin
                    state_next = sts.started ? ST_BODY : ST_PTR;
                end
            end
            ST_PTR: begin
                cmd.src  = SRC_PTR;
                cmd.step = step_ok;
                if (step_ok) begin
                    state_next = ST_BODY;
                end
            end
            ST_BODY: begin
                case (sel_reg)
                    SEL_C0:  cmd.src = SRC_CRC0;
                    SEL_C1:  cmd.src = SRC_CRC1;
                    SEL_C2:  cmd.src = SRC_CRC2;
                    SEL_C3:  cmd.src = SRC_CRC3;
                    default: cmd.src = SRC_DATA;
                endcase
                cmd.step = step_ok;
                if (step_ok) begin
                    if (!sts.last) begin
                        state_next = ST_IDLE;
                    end else if (sel_reg != SEL_C3) begin
                        sel_next   = sel_reg + 3'd1;
                        state_next = sts.pos_wrap ? ST_H0 : ST_BODY;
                    end else if (sts.pos_wrap) begin
                        cmd.end_section = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.src  = SRC_PAD;
                cmd.step = step_ok;
                if (step_ok && sts.pos_wrap) begin
                    cmd.end_section = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_DATA;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tspkt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module tspkt_dpath
    import tspkt_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tspkt_cmd_t       cmd,
    output tspkt_sts_t            sts,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             s_tlast,
    input  wire logic             cfg_we,
    input  wire logic [PID_W-1:0] cfg_wdata,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [31:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic [PID_W-1:0] pid_reg, pid_next;
    logic [31:0]      crc_reg, crc_next;
    logic [3:0]       cc_reg, cc_next;
    logic [3:0]       cc_inc;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [23:0]      asm_reg, asm_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             started_reg, started_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             valid_reg, valid_next;
    logic [31:0]      word_reg, word_next;
    logic             done_reg, done_next;
    logic             rlast_reg, rlast_next;
    logic [7:0]       cur_byte;
    logic             pos_wrap;
    logic             out_free;

    assign cc_inc   = cc_reg + 4'd1;
    assign pos_wrap = (pos_reg == POS_W'(PACKET_BYTES - 1));
    assign out_free = !valid_reg || m_tready;

    assign sts.pos_zero  = (pos_reg == '0);
    assign sts.pos_wrap  = pos_wrap;
    assign sts.word_full = (cnt_reg == 2'd3);
    assign sts.out_free  = out_free;
    assign sts.started   = started_reg;
    assign sts.last      = last_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = done_reg;
    assign m_tlast  = rlast_reg;

    always_comb begin
        unique case (cmd.src)
            SRC_H0:   cur_byte = SYNC_BYTE;
            SRC_H1:   cur_byte = {1'b0, !started_reg, 1'b0, pid_reg[12:8]};
            SRC_H2:   cur_byte = pid_reg[7:0];
            SRC_H3:   cur_byte = {CTRL_NIB, cc_inc};
            SRC_PTR:  cur_byte = PTR_BYTE;
            SRC_DATA: cur_byte = byte_reg;
            SRC_CRC0: cur_byte = crc_reg[31:24];
            SRC_CRC1: cur_byte = crc_reg[23:16];
            SRC_CRC2: cur_byte = crc_reg[15:8];
            SRC_CRC3: cur_byte = crc_reg[7:0];
            default:  cur_byte = PAD_BYTE;
        endcase
    end

    always_comb begin
        pid_next     = pid_reg;
        crc_next     = crc_reg;
        cc_next      = cc_reg;
        pos_next     = pos_reg;
        asm_next     = asm_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        valid_next   = valid_reg;
        word_next    = word_reg;
        done_next    = done_reg;
        rlast_next   = rlast_reg;

        if (cfg_we) begin
            pid_next = cfg_wdata;
        end
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (cmd.load) begin
            byte_next = s_tdata;
            last_next = s_tlast;
            crc_next  = crc32_byte(crc_reg, s_tdata);
        end
        if (cmd.step) begin
            pos_next = pos_wrap ? '0 : pos_reg + POS_W'(1);
            if (cnt_reg == 2'd3) begin
                word_next  = {asm_reg, cur_byte};
                valid_next = 1'b1;
                done_next  = pos_wrap;
                rlast_next = cmd.run_last;
                cnt_next   = 2'd0;
            end else begin
                asm_next = {asm_reg[15:0], cur_byte};
                cnt_next = cnt_reg + 2'd1;
            end
            if (cmd.src == SRC_H3) begin
                cc_next = cc_inc;
            end
            if (cmd.src == SRC_PTR) begin
                started_next = 1'b1;
            end
            if (cmd.end_section) begin
                started_next = 1'b0;
                crc_next     = CRC_INIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pid_reg     <= '0;
            crc_reg     <= CRC_INIT;
            cc_reg      <= '0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            last_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            pid_reg     <= pid_next;
            crc_reg     <= crc_next;
            cc_reg      <= cc_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
            last_reg    <= last_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        asm_reg   <= asm_next;
        byte_reg  <= byte_next;
        word_reg  <= word_next;
        done_reg  <= done_next;
        rlast_reg <= rlast_next;
    end

endmodule

`default_nettype wire

### rtl/ts_section_packetizer_crc32.sv
// An accepted byte is registered, then packed into the 32-bit output word;
// one that opens a packet first waits for header states H0-H3 and, on a
// section's first packet, PTR. A section's final byte is followed by four
// CRC bytes, padding up to the 188-byte packet end, and a header per packet.
// The controller takes one byte per return to idle; m_tready low stalls it.
// Reset (aresetn low, synchronous): PID, continuity counter and position clear.
`timescale 1ns / 1ps
`default_nettype none

module ts_section_packetizer_crc32
    import tspkt_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] section_byte
    input  wire logic             s_tlast,
    input  wire logic             cfg_we,
    input  wire logic [PID_W-1:0] cfg_wdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,   // [31:0] out_word
    output logic                  m_tuser,   // [0] packet_done
    output logic                  m_tlast
);

    tspkt_cmd_t cmd;
    tspkt_sts_t sts;

    tspkt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tspkt_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/tspkt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tspkt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output transfer changed");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous byte in work");

    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser && !m_tlast |=> !s_tready)
        else $error("packet ended mid-item while input open");

endmodule

bind ts_section_packetizer_crc32 tspkt_checker u_tspkt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/tb_ts_section_packetizer_crc32.sv
`timescale 1ns / 1ps

module tb_ts_section_packetizer_crc32;
    import tspkt_pkg::*;

    localparam int          HOLD_CYCLES = 400;
    localparam int          SETTLE      = 12;
    localparam logic [7:0]  START_FLAG  = 8'h40;

    typedef enum logic { ROW_BYTE, ROW_PID } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [12:0] value;
        logic        last;
        logic        typed;
        logic [31:0] exp_word;
    } stim_row_t;

    typedef struct {
        logic [31:0] word;
        logic        done;
        logic        last;
    } ts_word_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [PID_W-1:0]  cfg_wdata = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    ts_word_t ts_words_due[$];
    ts_word_t word_due;
    int       mismatches   = 0;
    int       tx_idle_pct  = 0;
    int       rx_stall_pct = 0;
    int       hold_asked   = 0;
    int       hold_served  = 0;
    int       hold_left    = 0;

    logic [12:0] pid_model;
    logic [31:0] crc_run;
    logic [3:0]  cont_cnt;
    logic [7:0]  pkt_pos;
    logic [23:0] asm_bytes;
    logic [1:0]  asm_cnt;
    logic        in_section;

    stim_row_t directed_rows [17] = '{
        '{ROW_BYTE, 13'h000,  1'b0, 1'b1, 32'h4740_0011},
        '{ROW_BYTE, 13'h0FF,  1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h080,  1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h001,  1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h07F,  1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h055,  1'b1, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h0AA,  1'b1, 1'b0, 32'h0},
        '{ROW_PID,  13'h1FFF, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h0FF,  1'b0, 1'b1, 32'h475F_FF13},
        '{ROW_BYTE, 13'h000,  1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h0FF,  1'b1, 1'b0, 32'h0},
        '{ROW_PID,  13'h0100, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h012,  1'b1, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h034,  1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h056,  1'b0, 1'b0, 32'h0},
        '{ROW_PID,  13'h0A5A, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 13'h078,  1'b1, 1'b0, 32'h0}
    };

    ts_section_packetizer_crc32 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic crc_absorb(input logic [7:0] b);
        logic [31:0] c;
        c = crc_run ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        crc_run = c;
    endtask

    task automatic stream_byte(input logic [7:0] b);
        ts_word_t w;
        logic     done;
        done    = (pkt_pos + 8'd1 == PACKET_BYTES);
        pkt_pos = done ? 8'd0 : pkt_pos + 8'd1;
        if (asm_cnt == 2'd3) begin
            w.word = {asm_bytes, b};
            w.done = done;
            w.last = 1'b0;
            ts_words_due = {ts_words_due, w};
            asm_bytes = '0;
            asm_cnt   = '0;
        end else begin
            asm_bytes = {asm_bytes[15:0], b};
            asm_cnt   = asm_cnt + 2'd1;
        end
    endtask

    task automatic frame_byte(input logic [7:0] b);
        if (pkt_pos == 8'd0) begin
            stream_byte(SYNC_BYTE);
            stream_byte((in_section ? 8'h00 : START_FLAG) | {3'b000, pid_model[12:8]});
            stream_byte(pid_model[7:0]);
            cont_cnt = cont_cnt + 4'd1;
            stream_byte({CTRL_NIB, cont_cnt});
            if (!in_section) begin
                stream_byte(PTR_BYTE);
                in_section = 1'b1;
            end
        end
        stream_byte(b);
    endtask

    task automatic packetize_byte(input logic [7:0] b, input logic last,
                                  output int first_idx);
        logic [31:0] c;
        first_idx = ts_words_due.size();
        crc_absorb(b);
        frame_byte(b);
        if (last) begin
            c = crc_run;
            frame_byte(c[31:24]);
            frame_byte(c[23:16]);
            frame_byte(c[15:8]);
            frame_byte(c[7:0]);
            while (pkt_pos != 8'd0) begin
                stream_byte(PAD_BYTE);
            end
            crc_run    = CRC_INIT;
            in_section = 1'b0;
        end
        if (ts_words_due.size() > first_idx) begin
            ts_words_due[ts_words_due.size() - 1].last = 1'b1;
        end
    endtask

    task automatic send_section_byte(input logic [7:0] b, input logic last,
                                     output int first_idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        packetize_byte(b, last, first_idx);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (ts_words_due.size() > 0 && guard < 200_000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_pid(input logic [12:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pid_model = v;
    endtask

    function automatic int section_length();
        if ($urandom_range(11) != 0) begin
            return $urandom_range(1, 12);
        end
        case ($urandom_range(5))
            0: return 179;
            1: return 180;
            2: return 183;
            3: return 184;
            4: return 187;
            default: return $urandom_range(300, 380);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (ts_words_due.size() == 0) begin
                note_mismatch($sformatf("unexpected word %h", m_tdata));
            end else begin
                word_due = ts_words_due[0];
                ts_words_due.delete(0);
                if (m_tdata !== word_due.word) begin
                    note_mismatch($sformatf("out_word got %h want %h", m_tdata, word_due.word));
                end
                if (m_tuser !== word_due.done) begin
                    note_mismatch($sformatf("packet_done got %b want %b on word %h",
                                            m_tuser, word_due.done, word_due.word));
                end
                if (m_tlast !== word_due.last) begin
                    note_mismatch($sformatf("run_last got %b want %b on word %h",
                                            m_tlast, word_due.last, word_due.word));
                end
            end
        end
    end

    initial begin
        stim_row_t   row;
        int          first_idx;
        int          rand_items;
        int          left;
        logic [7:0]  b;
        logic        l;
        logic [12:0] phase_pid [4];

        pid_model  = '0;
        crc_run    = CRC_INIT;
        cont_cnt   = '0;
        pkt_pos    = '0;
        asm_bytes  = '0;
        asm_cnt    = '0;
        in_section = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_PID) begin
                write_pid(row.value);
            end else begin
                send_section_byte(row.value[7:0], row.last, first_idx);
                if (row.typed && ts_words_due.size() > first_idx) begin
                    ts_words_due[first_idx].word = row.exp_word;
                end
            end
        end

        phase_pid[0] = 13'($urandom_range(8191));
        phase_pid[1] = 13'h1FFF;
        phase_pid[2] = 13'h0000;
        phase_pid[3] = 13'($urandom_range(8191));
        rand_items      = 0;
        left            = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_pid(phase_pid[ph]);
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            while (rand_items < (ph + 1) * 95) begin
                if (ph == 0 && rand_items == 20) begin
                    hold_asked++;
                end
                if (left == 0) begin
                    left = section_length();
                end
                b = 8'($urandom_range(255));
                l = (left == 1) || (rand_items == 4 * 95 - 1);
                send_section_byte(b, l, first_idx);
                left = l ? 0 : left - 1;
                rand_items++;
            end
        end

        wait_drained();
        if (ts_words_due.size() != 0) begin
            note_mismatch($sformatf("%0d words never arrived", ts_words_due.size()));
        end
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
